@@ src/dtrrs_pkg.sv @@
// Shared types and constants for the delay timer round-robin scheduler.
// Field widths, action codes, controller state and command bundle.
// Depends on nothing.
package dtrrs_pkg;

   localparam int ACTION_WIDTH         = 2;
   localparam int THREAD_FIELD_WIDTH   = 3;
   localparam int COUNT_FIELD_WIDTH    = 16;
   localparam int MASK_FIELD_WIDTH     = 8;
   localparam int MILLIS_WIDTH         = 32;

   localparam int THREAD_COUNT_DEFAULT = 8;
   localparam int DELAY_WIDTH_DEFAULT  = 16;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_TICK        = 2'd0,
      ACT_SCHEDULE    = 2'd1,
      ACT_START_DELAY = 2'd2
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

@@ src/dtrrs_ctrl.sv @@
// Controller for the scheduler: handshake on both channels and sequencing.
// Drives capture and execute commands to dtrrs_datapath; uses dtrrs_pkg.
module dtrrs_ctrl
   import dtrrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      req_stall   = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the previous beat has left the output
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/dtrrs_datapath.sv @@
// Datapath for the scheduler: input registers, delay counter lanes,
// millisecond clock and round-robin pick. Commanded by dtrrs_ctrl; uses dtrrs_pkg.
module dtrrs_datapath
   import dtrrs_pkg::*;
#(
   parameter int THREAD_COUNT = THREAD_COUNT_DEFAULT,
   parameter int DELAY_WIDTH  = DELAY_WIDTH_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   input  logic [ACTION_WIDTH-1:0]       req_action,
   input  logic [THREAD_FIELD_WIDTH-1:0] req_thread,
   input  logic [COUNT_FIELD_WIDTH-1:0]  req_delay_count,
   input  logic [MASK_FIELD_WIDTH-1:0]   req_disable_mask,
   output logic [THREAD_FIELD_WIDTH-1:0] rsp_next_thread,
   output logic                          rsp_found,
   output logic [MASK_FIELD_WIDTH-1:0]   rsp_delayed_mask,
   output logic [MILLIS_WIDTH-1:0]       rsp_elapsed_ms
);

   localparam int TW = $clog2(THREAD_COUNT);

   logic [ACTION_WIDTH-1:0]       action_ff;
   logic [THREAD_FIELD_WIDTH-1:0] thread_ff;
   logic [COUNT_FIELD_WIDTH-1:0]  count_ff;
   logic [MASK_FIELD_WIDTH-1:0]   disable_ff;

   logic [DELAY_WIDTH-1:0]  counter_ff [THREAD_COUNT];
   logic [DELAY_WIDTH-1:0]  counter_in [THREAD_COUNT];
   logic [THREAD_COUNT-1:0] active_ff, active_in;
   logic [TW-1:0]           cur_ff, cur_in;
   logic [MILLIS_WIDTH-1:0] millis_ff, millis_in;
   logic                    found_ff, found_in;

   logic [TW-1:0]             thread_idx;
   logic                      thread_ok;
   logic [DELAY_WIDTH-1:0]    new_count;
   logic [THREAD_COUNT-1:0]   ready;
   logic [TW-1:0]             start;
   logic [2*THREAD_COUNT-1:0] doubled;
   logic [THREAD_COUNT-1:0]   rotated;
   logic [TW-1:0]             offset;
   logic [TW:0]               pick_sum;
   logic [TW-1:0]             pick;
   logic [DELAY_WIDTH-1:0]    dec;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_action;
         thread_ff  <= req_thread;
         count_ff   <= req_delay_count;
         disable_ff <= req_disable_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREAD_COUNT; i++) begin
            counter_ff[i] <= '0;
         end
         active_ff <= '0;
         cur_ff    <= '0;
         millis_ff <= '0;
         found_ff  <= 1'b0;
      end else if (cmd.execute) begin
         for (int i = 0; i < THREAD_COUNT; i++) begin
            counter_ff[i] <= counter_in[i];
         end
         active_ff <= active_in;
         cur_ff    <= cur_in;
         millis_ff <= millis_in;
         found_ff  <= found_in;
      end
   end

   assign thread_idx = TW'(thread_ff);
   assign thread_ok  = (int'(thread_ff) < THREAD_COUNT);
   assign new_count  = DELAY_WIDTH'(count_ff);

   assign ready   = ~(THREAD_COUNT'(disable_ff) | active_ff);
   assign start   = (cur_ff == TW'(THREAD_COUNT - 1)) ? '0 : cur_ff + 1'b1;
   assign doubled = {ready, ready} >> start;
   assign rotated = doubled[THREAD_COUNT-1:0];

   always_comb begin
      offset = '0;
      for (int i = THREAD_COUNT - 1; i >= 0; i--) begin
         if (rotated[i]) begin
            offset = TW'(i);
         end
      end
   end

   assign pick_sum = {1'b0, start} + {1'b0, offset};
   assign pick     = (pick_sum >= (TW+1)'(THREAD_COUNT)) ?
                     TW'(pick_sum - (TW+1)'(THREAD_COUNT)) : pick_sum[TW-1:0];

   always_comb begin
      for (int i = 0; i < THREAD_COUNT; i++) begin
         counter_in[i] = counter_ff[i];
      end
      active_in = active_ff;
      cur_in    = cur_ff;
      millis_in = millis_ff;
      found_in  = 1'b0;
      dec       = '0;
      case (action_ff)
         ACT_TICK: begin
            for (int i = 0; i < THREAD_COUNT; i++) begin
               dec = counter_ff[i] - 1'b1;
               if (active_ff[i]) begin
                  counter_in[i] = dec;
                  if (dec == '0) begin
                     active_in[i] = 1'b0;
                  end
               end
            end
            millis_in = millis_ff + 1'b1;
         end
         ACT_SCHEDULE: begin
            if (|ready) begin
               cur_in   = pick;
               found_in = 1'b1;
            end
         end
         ACT_START_DELAY: begin
            for (int i = 0; i < THREAD_COUNT; i++) begin
               if (thread_ok && thread_idx == TW'(i)) begin
                  counter_in[i] = new_count;
                  active_in[i]  = (new_count != '0);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_next_thread  = THREAD_FIELD_WIDTH'(cur_ff);
   assign rsp_found        = found_ff;
   assign rsp_delayed_mask = MASK_FIELD_WIDTH'(active_ff);
   assign rsp_elapsed_ms   = millis_ff;

endmodule

@@ src/delay_timer_round_robin_scheduler_core.sv @@
// Top level of the delay timer round-robin scheduler.
// Joins dtrrs_ctrl and dtrrs_datapath; uses dtrrs_pkg.
//
// Each request beat is one action: a millisecond tick that counts down every
// running delay and advances the 32-bit clock, a schedule that picks the next
// ready thread round-robin after the current one (current thread tried last),
// or a start-delay that arms one thread's counter. Every request gives exactly
// one response beat carrying the current thread, the found flag, the delayed
// mask and the elapsed milliseconds. A beat first registers the request;
// then the datapath updates all counter lanes and makes the pick in parallel.
// The request side is stalled while a beat is in work, and the update waits
// while the previous response is still stalled on the output.
module delay_timer_round_robin_scheduler_core
   import dtrrs_pkg::*;
#(
   parameter int THREAD_COUNT = THREAD_COUNT_DEFAULT,
   parameter int DELAY_WIDTH  = DELAY_WIDTH_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ACTION_WIDTH-1:0]       req_action,
   input  logic [THREAD_FIELD_WIDTH-1:0] req_thread,
   input  logic [COUNT_FIELD_WIDTH-1:0]  req_delay_count,
   input  logic [MASK_FIELD_WIDTH-1:0]   req_disable_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [THREAD_FIELD_WIDTH-1:0] rsp_next_thread,
   output logic                          rsp_found,
   output logic [MASK_FIELD_WIDTH-1:0]   rsp_delayed_mask,
   output logic [MILLIS_WIDTH-1:0]       rsp_elapsed_ms
);

   ctrl_cmd_type cmd;

   dtrrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dtrrs_datapath #(
      .THREAD_COUNT (THREAD_COUNT),
      .DELAY_WIDTH  (DELAY_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_thread       (req_thread),
      .req_delay_count  (req_delay_count),
      .req_disable_mask (req_disable_mask),
      .rsp_next_thread  (rsp_next_thread),
      .rsp_found        (rsp_found),
      .rsp_delayed_mask (rsp_delayed_mask),
      .rsp_elapsed_ms   (rsp_elapsed_ms)
   );

endmodule
